### src/multilevel_feedback_thread_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler top level.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MFTS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define MFTS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### src/mfts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, codes and command/status types shared by the scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfts_pkg;

  localparam int MAX_THREADS = 64;
  localparam int TID_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  localparam int ID_W       = 6;
  localparam int LVL_W      = 2;
  localparam int SLICE_W    = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIDE_W     = ((TID_W > ID_W) ? TID_W : ID_W) + 1;

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YIELD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXIT   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_JOIN   = 2'd3;

  localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
  localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_ONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TWO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_THREE = 2'd2;

  typedef struct packed {
    logic capture;
    logic enqueue;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic passive;
  } dp_status_t;

  typedef struct packed {
    logic [ID_W-1:0]    running_id;
    logic [LVL_W-1:0]   running_level;
    logic [SLICE_W-1:0] slice_ticks;
    logic               switched;
    logic [ID_W-1:0]    created_id;
    logic               status;
    logic               join_done;
  } result_t;

endpackage

### src/mfts_req_if.sv
// ----------------------------------------------------------------------------
// Scheduler event channel
// Valid/ready channel that carries one scheduling event per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfts_req_if;
  import mfts_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   query_id;

  modport source (output valid, output mode, output query_id, input ready);
  modport sink (input valid, input mode, input query_id, output ready);
endinterface

### src/mfts_rsp_if.sv
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel that carries one scheduling result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mfts_rsp_if;
  import mfts_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    running_id;
  logic [LVL_W-1:0]   running_level;
  logic [SLICE_W-1:0] slice_ticks;
  logic               switched;
  logic [ID_W-1:0]    created_id;
  logic               status;
  logic               join_done;

  modport source (
    output valid, output running_id, output running_level, output slice_ticks,
    output switched, output created_id, output status, output join_done,
    input ready
  );
  modport sink (
    input valid, input running_id, input running_level, input slice_ticks,
    input switched, input created_id, input status, input join_done,
    output ready
  );
endinterface

### src/mfts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Queue update, head read and commit per event; passive events only commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  mfts_pkg::dp_status_t stat,
  output mfts_pkg::dp_cmd_t    cmd
);
  import mfts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ENQ  = 2'd1;
  localparam logic [1:0] ST_HEAD = 2'd2;
  localparam logic [1:0] ST_PICK = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_valid = out_valid;

  assign cmd.capture = accept;
  assign cmd.enqueue = (state == ST_ENQ);
  assign cmd.commit  = (state == ST_PICK) && (!out_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = stat.passive ? ST_PICK : ST_ENQ;
        end
      end
      ST_ENQ:  state_next = ST_HEAD;
      ST_HEAD: state_next = ST_PICK;
      ST_PICK: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

### src/mfts_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Level queues, thread table, slice registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfts_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [mfts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfts_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mfts_pkg::MODE_W-1:0]         mode,
  input  logic [mfts_pkg::ID_W-1:0]           query_id,
  input  mfts_pkg::dp_cmd_t                   cmd,
  output mfts_pkg::dp_status_t                stat,
  output mfts_pkg::result_t                   res
);
  import mfts_pkg::*;

  logic [SLICE_W-1:0]   slice_one;
  logic [SLICE_W-1:0]   slice_two;
  logic [SLICE_W-1:0]   slice_three;
  logic [TID_W-1:0]     current_id;
  logic [LVL_W-1:0]     current_level;
  logic [CNT_W-1:0]     next_id;
  logic [MAX_THREADS-1:0] exited;

  logic [LVL_W-1:0]     tl_mem [MAX_THREADS];
  logic [LVL_W-1:0]     tl_rd;

  logic [MODE_W-1:0]    mode_q;
  logic [ID_W-1:0]      qid_q;
  logic                 passive_q;
  logic [TID_W-1:0]     created_q;

  logic                 table_full;
  logic                 active_enq;
  logic                 do_demote;
  logic [LVL_W-1:0]     demote_lvl;
  logic [2:0]           enq_en;
  logic [TID_W-1:0]     enq_data [3];
  logic [2:0]           deq_en;
  logic [2:0]           q_nonempty;
  logic [TID_W-1:0]     q_front [3];
  logic [2:0]           cand;
  logic [2:0]           pick;
  logic [TID_W-1:0]     new_id;
  logic [LVL_W-1:0]     new_level;
  logic [TID_W-1:0]     out_id;
  logic [LVL_W-1:0]     out_level;
  logic                 qid_in_range;

  function automatic logic [TID_W-1:0] advance(input logic [TID_W-1:0] p);
    logic [TID_W:0] nxt;
    nxt = {1'b0, p} + (TID_W+1)'(1);
    return (nxt >= (TID_W+1)'(MAX_THREADS)) ? '0 : nxt[TID_W-1:0];
  endfunction

  function automatic logic [SLICE_W-1:0] slice_of(input logic [LVL_W-1:0] lvl,
                                                  input logic [SLICE_W-1:0] s1,
                                                  input logic [SLICE_W-1:0] s2,
                                                  input logic [SLICE_W-1:0] s3);
    logic [SLICE_W-1:0] s;
    case (lvl)
      LVL_TWO:   s = s2;
      LVL_THREE: s = s3;
      default:   s = s1;
    endcase
    return s;
  endfunction

  assign table_full   = (next_id >= CNT_W'(MAX_THREADS));
  assign stat.passive = (mode == MODE_JOIN) || ((mode == MODE_CREATE) && table_full);

  assign active_enq = cmd.enqueue && !passive_q;
  assign do_demote  = active_enq && ((mode_q == MODE_CREATE) || (mode_q == MODE_YIELD)) &&
                      (current_id != '0);
  assign demote_lvl = (tl_rd >= LVL_TWO) ? LVL_THREE : LVL_TWO;

  assign enq_en[0]   = active_enq && (mode_q == MODE_CREATE);
  assign enq_en[1]   = do_demote && (demote_lvl == LVL_TWO);
  assign enq_en[2]   = do_demote && (demote_lvl == LVL_THREE);
  assign enq_data[0] = created_q;
  assign enq_data[1] = current_id;
  assign enq_data[2] = current_id;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cand[l] = q_nonempty[l] && (q_front[l] != current_id);
    end
  end

  assign pick[0] = cand[0];
  assign pick[1] = cand[1] && !cand[0];
  assign pick[2] = cand[2] && !cand[1] && !cand[0];

  always_comb begin
    new_id    = '0;
    new_level = LVL_ONE;
    if (pick[0]) begin
      new_id    = q_front[0];
      new_level = LVL_ONE;
    end else if (pick[1]) begin
      new_id    = q_front[1];
      new_level = LVL_TWO;
    end else if (pick[2]) begin
      new_id    = q_front[2];
      new_level = LVL_THREE;
    end
  end

  assign deq_en = (cmd.commit && !passive_q) ? pick : 3'b000;

  genvar gi;
  generate
    for (gi = 0; gi < 3; gi++) begin : g_queue
      logic [TID_W-1:0] mem [MAX_THREADS];
      logic [TID_W-1:0] head;
      logic [TID_W-1:0] tail;
      logic [CNT_W-1:0] count;
      logic [TID_W-1:0] front;
      logic             has_room;

      assign has_room        = (count < CNT_W'(MAX_THREADS));
      assign q_nonempty[gi]  = (count != '0);
      assign q_front[gi]     = front;

      always_ff @(posedge clk) begin
        if (enq_en[gi] && has_room) begin
          mem[tail] <= enq_data[gi];
        end
        front <= mem[head];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          head  <= '0;
          tail  <= '0;
          count <= '0;
        end else if (enq_en[gi] && has_room) begin
          tail  <= advance(tail);
          count <= count + CNT_W'(1);
        end else if (deq_en[gi]) begin
          head  <= advance(head);
          count <= count - CNT_W'(1);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.capture && (mode == MODE_CREATE) && !table_full) begin
      tl_mem[next_id[TID_W-1:0]] <= LVL_ONE;
    end else if (do_demote) begin
      tl_mem[current_id] <= demote_lvl;
    end
    tl_rd <= tl_mem[current_id];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q    <= mode;
      qid_q     <= query_id;
      passive_q <= stat.passive;
      created_q <= ((mode == MODE_CREATE) && !table_full) ? next_id[TID_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_one   <= '0;
      slice_two   <= '0;
      slice_three <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SLICE_ONE:   slice_one   <= cfg_data;
        CFG_SLICE_TWO:   slice_two   <= cfg_data;
        CFG_SLICE_THREE: slice_three <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_id    <= '0;
      current_level <= LVL_ONE;
      next_id       <= CNT_W'(1);
      exited        <= '0;
    end else begin
      if (active_enq && (mode_q == MODE_CREATE)) begin
        next_id           <= next_id + CNT_W'(1);
        exited[created_q] <= 1'b0;
      end
      if (active_enq && (mode_q == MODE_EXIT)) begin
        exited[current_id] <= 1'b1;
      end
      if (cmd.commit && !passive_q) begin
        current_id    <= new_id;
        current_level <= new_level;
      end
    end
  end

  assign out_id       = passive_q ? current_id : new_id;
  assign out_level    = passive_q ? current_level : new_level;
  assign qid_in_range = (WIDE_W'(qid_q) < WIDE_W'(MAX_THREADS));

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.running_id    <= ID_W'(out_id);
      res.running_level <= out_level;
      res.slice_ticks   <= slice_of(out_level, slice_one, slice_two, slice_three);
      res.switched      <= !passive_q && !((new_id == '0) && (current_id == '0));
      res.created_id    <= ID_W'(created_q);
      res.status        <= passive_q && (mode_q == MODE_CREATE);
      res.join_done     <= (mode_q == MODE_JOIN) && qid_in_range &&
                           exited[TID_W'(qid_q)];
    end
  end
endmodule

### src/multilevel_feedback_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel feedback thread scheduler
// Create, yield and exit pass through queue update, head read and commit.
// Join query or refused create goes straight to commit; one event at a time.
// Pace set by the registered head read of the level queue memories.
// Synchronous reset clears control state at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multilevel_feedback_thread_scheduler_defines.svh"

module multilevel_feedback_thread_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mfts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfts_pkg::CFG_DATA_W-1:0] cfg_data,
  mfts_req_if.sink                        req,
  mfts_rsp_if.source                      rsp
);
  import mfts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;
  result_t    res;

  mfts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mfts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (req.mode),
    .query_id  (req.query_id),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  assign rsp.running_id    = res.running_id;
  assign rsp.running_level = res.running_level;
  assign rsp.slice_ticks   = res.slice_ticks;
  assign rsp.switched      = res.switched;
  assign rsp.created_id    = res.created_id;
  assign rsp.status        = res.status;
  assign rsp.join_done     = res.join_done;

  `MFTS_ASSERT_IMP(a_commit_slot_free, clk, rst, cmd.commit, !rsp.valid || rsp.ready)
  `MFTS_ASSERT_NEXT(a_one_in_flight, clk, rst, req.valid && req.ready, !req.ready)
  `MFTS_ASSERT_IMP(a_refused_no_id, clk, rst, rsp.valid && rsp.status, rsp.created_id == '0)
endmodule

### tb/sv/multilevel_feedback_thread_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Multilevel feedback thread scheduler testbench
// Drives create, yield, exit and join events through the event channel and
// checks every result against a cycle-free scheduler model kept in the bench.
// A short directed sequence is followed by weighted random events over four
// slice settings, with random gaps on the event side and random stalls on
// the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multilevel_feedback_thread_scheduler_tb;
  import mfts_pkg::*;

  localparam int  RANDOM_PER_PHASE = 400;
  localparam int  PHASES           = 4;
  localparam int  DRAIN_CYCLES     = 20;
  localparam int  REPORT_LIMIT     = 10;
  localparam real TIMEOUT_NS       = 5000000.0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   query_id;
  } sched_event_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mfts_req_if sched_req ();
  mfts_rsp_if sched_rsp ();

  multilevel_feedback_thread_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (sched_req),
    .rsp       (sched_rsp)
  );

  // Scheduler state as the bench expects it.
  logic [SLICE_W-1:0] slice_cfg [3];
  int                 cur_thread;
  int                 cur_level;
  int                 next_tid;
  int                 thread_lvl [MAX_THREADS];
  bit                 has_exited [MAX_THREADS];
  int                 fifo_mem   [3][MAX_THREADS];
  int                 fifo_head  [3];
  int                 fifo_tail  [3];
  int                 fifo_count [3];

  sched_event_t pending_events [$];
  result_t      expected_results [$];
  int           fail_count;
  int           result_index;
  bit           presenting;
  int           gap_left;
  int           hold_cycles;
  bit           send_calm;
  bit           recv_calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void append_thread(int l, int tid);
    if (fifo_count[l] >= MAX_THREADS) return;
    fifo_mem[l][fifo_tail[l]] = tid;
    fifo_tail[l] = (fifo_tail[l] + 1) % MAX_THREADS;
    fifo_count[l]++;
  endfunction

  function automatic void demote_thread(int tid);
    int lv;
    if (tid == 0) return;
    lv = thread_lvl[tid];
    if (lv < 1) lv = 1;
    if (lv < 3) lv++;
    thread_lvl[tid] = lv;
    append_thread(lv - 1, tid);
  endfunction

  function automatic result_t schedule_event(logic [MODE_W-1:0] mode,
                                             logic [ID_W-1:0] qid);
    result_t r;
    int      prev;
    bit      found;
    r = '0;
    if (mode == MODE_JOIN) begin
      r.join_done = has_exited[qid];
    end else if (mode == MODE_CREATE && next_tid >= MAX_THREADS) begin
      r.status = 1'b1;
    end else begin
      prev = cur_thread;
      if (mode == MODE_CREATE) begin
        thread_lvl[next_tid] = 1;
        has_exited[next_tid] = 1'b0;
        append_thread(0, next_tid);
        r.created_id = next_tid[ID_W-1:0];
        next_tid++;
        demote_thread(prev);
      end else if (mode == MODE_YIELD) begin
        demote_thread(prev);
      end else begin
        has_exited[prev] = 1'b1;
      end
      found = 1'b0;
      for (int l = 0; l < 3 && !found; l++) begin
        if (fifo_count[l] != 0 && fifo_mem[l][fifo_head[l]] != prev) begin
          cur_thread = fifo_mem[l][fifo_head[l]];
          fifo_head[l] = (fifo_head[l] + 1) % MAX_THREADS;
          fifo_count[l]--;
          cur_level = l + 1;
          found = 1'b1;
        end
      end
      if (!found) begin
        cur_thread = 0;
        cur_level = 1;
      end
      r.switched = !(cur_thread == 0 && prev == 0);
    end
    r.running_id    = cur_thread[ID_W-1:0];
    r.running_level = cur_level[LVL_W-1:0];
    r.slice_ticks   = slice_cfg[cur_level - 1];
    return r;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  task automatic push_event(logic [MODE_W-1:0] mode, logic [ID_W-1:0] qid);
    sched_event_t ev;
    ev.mode = mode;
    ev.query_id = qid;
    pending_events.push_back(ev);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || presenting || expected_results.size() != 0);
  endtask

  // Event side: one transfer per presented item, then a random gap.
  always @(posedge clk) begin
    sched_event_t ev;
    if (rst) begin
      sched_req.valid <= 1'b0;
      presenting = 1'b0;
      gap_left = 0;
    end else begin
      if (sched_req.valid && sched_req.ready) begin
        expected_results.push_back(schedule_event(sched_req.mode, sched_req.query_id));
        presenting = 1'b0;
        gap_left = draw_wait(send_calm);
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() != 0) begin
          ev = pending_events.pop_front();
          sched_req.mode <= ev.mode;
          sched_req.query_id <= ev.query_id;
          presenting = 1'b1;
        end
      end
      sched_req.valid <= presenting;
    end
  end

  // Result side: check each transfer, then stall for a random time.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      sched_rsp.ready <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (sched_rsp.valid && sched_rsp.ready) begin
        got.running_id    = sched_rsp.running_id;
        got.running_level = sched_rsp.running_level;
        got.slice_ticks   = sched_rsp.slice_ticks;
        got.switched      = sched_rsp.switched;
        got.created_id    = sched_rsp.created_id;
        got.status        = sched_rsp.status;
        got.join_done     = sched_rsp.join_done;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected", result_index));
        end else begin
          want = expected_results.pop_front();
          if (got.running_id !== want.running_id ||
              got.running_level !== want.running_level ||
              got.slice_ticks !== want.slice_ticks ||
              got.switched !== want.switched ||
              got.created_id !== want.created_id ||
              got.status !== want.status ||
              got.join_done !== want.join_done) begin
            note_failure($sformatf(
              {"result %0d mismatch: expected id=%0d lvl=%0d slice=%h sw=%b new=%0d ",
               "st=%b join=%b, got id=%0d lvl=%0d slice=%h sw=%b new=%0d st=%b join=%b"},
              result_index, want.running_id, want.running_level, want.slice_ticks,
              want.switched, want.created_id, want.status, want.join_done,
              got.running_id, got.running_level, got.slice_ticks, got.switched,
              got.created_id, got.status, got.join_done));
          end
        end
        result_index++;
        hold_cycles = draw_wait(recv_calm);
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      sched_rsp.ready <= (hold_cycles == 0);
    end
  end

  initial begin
    logic [CFG_IDX_W-1:0]  cfg_regs [3];
    logic [CFG_DATA_W-1:0] cfg_vals [3];
    int                    pick;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SLICE_ONE;
    cfg_data = '0;
    sched_req.valid = 1'b0;
    sched_req.mode = MODE_CREATE;
    sched_req.query_id = '0;
    sched_rsp.ready = 1'b0;
    fail_count = 0;
    result_index = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    cur_thread = 0;
    cur_level = 1;
    next_tid = 1;
    for (int i = 0; i < MAX_THREADS; i++) begin
      thread_lvl[i] = 0;
      has_exited[i] = 1'b0;
    end
    for (int l = 0; l < 3; l++) begin
      slice_cfg[l] = '0;
      fifo_head[l] = 0;
      fifo_tail[l] = 0;
      fifo_count[l] = 0;
    end
    cfg_regs[0] = CFG_SLICE_ONE;
    cfg_regs[1] = CFG_SLICE_TWO;
    cfg_regs[2] = CFG_SLICE_THREE;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      case (phase)
        0: begin
          cfg_vals[0] = 16'hFFFF;
          cfg_vals[1] = 16'h0000;
          cfg_vals[2] = 16'h1234;
        end
        1: begin
          cfg_vals[0] = 16'h0000;
          cfg_vals[1] = 16'hFFFF;
          cfg_vals[2] = 16'h8001;
        end
        2: begin
          cfg_vals[0] = 16'($urandom);
          cfg_vals[1] = 16'($urandom);
          cfg_vals[2] = 16'h0000;
        end
        default: begin
          cfg_vals[0] = 16'($urandom);
          cfg_vals[1] = 16'($urandom);
          cfg_vals[2] = 16'hFFFF;
        end
      endcase
      for (int r = 0; r < 3; r++) begin
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= cfg_regs[r];
        cfg_data <= cfg_vals[r];
        slice_cfg[cfg_regs[r]] = cfg_vals[r];
      end
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);

      if (phase == 0) begin
        // Main yields and exits while alone, then joins on main and an unused thread.
        push_event(MODE_YIELD, 6'd0);
        push_event(MODE_EXIT, 6'd0);
        push_event(MODE_JOIN, 6'd0);
        push_event(MODE_JOIN, 6'h3F);
        push_event(MODE_CREATE, 6'h3F);
        push_event(MODE_CREATE, 6'd0);
        push_event(MODE_JOIN, 6'd1);
        // Two threads demote down to the lowest level and keep alternating.
        push_event(MODE_YIELD, 6'h2A);
        push_event(MODE_YIELD, 6'h15);
        push_event(MODE_YIELD, 6'h2A);
        push_event(MODE_YIELD, 6'h15);
        push_event(MODE_YIELD, 6'h2A);
        push_event(MODE_YIELD, 6'h15);
        push_event(MODE_EXIT, 6'd0);
        push_event(MODE_JOIN, 6'd1);
        push_event(MODE_JOIN, 6'd2);
        push_event(MODE_EXIT, 6'd0);
        // A lone thread that yields is skipped as queue head, so main runs.
        push_event(MODE_CREATE, 6'd0);
        push_event(MODE_YIELD, 6'd0);
        push_event(MODE_YIELD, 6'd0);
        push_event(MODE_EXIT, 6'd0);
        push_event(MODE_JOIN, 6'd3);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) push_event(MODE_CREATE, 6'($urandom));
        else if (pick < 14) push_event(MODE_EXIT, 6'($urandom));
        else if (pick < 70) push_event(MODE_YIELD, 6'($urandom));
        else push_event(MODE_JOIN, 6'($urandom));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[multilevel_feedback_thread_scheduler] OK");
    end else begin
      $display("[multilevel_feedback_thread_scheduler] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[multilevel_feedback_thread_scheduler] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/mfts_pkg.sv
src/mfts_req_if.sv
src/mfts_rsp_if.sv
src/mfts_ctrl.sv
src/mfts_datapath.sv
src/multilevel_feedback_thread_scheduler.sv
tb/sv/multilevel_feedback_thread_scheduler_tb.sv
